// ===== rtl/hsk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsk_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W     = 16;
    localparam int ID_W      = 16;
    localparam int PLD_W     = 32;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    // word index of the direction register
    localparam logic [PADDR_W-3:0] REG_SORT_DESC = '0;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        logic [PLD_W-1:0] payload;
    } rec_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        rec_t             data;
    } ram_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLD,
        ST_BLD_LD,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_SIFT_C,
        ST_SIFT_D,
        ST_SRT,
        ST_SRT_R0,
        ST_SRT_WE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/heap_sort_by_key_top.sv =====
//  channel   | handshake                      | beat contents
//  ----------+--------------------------------+-------------------------------------
//  input     | start && !busy                 | sort_key, item_id, payload, last_item
//  result    | out_valid (one cycle, no stall)| out_key, out_id, out_payload,
//            |                                | out_last, out_dropped
//  config    | APB psel/penable/pwrite/pready | 0x0: sort_descending (bit 0)
//
//  Load: one record a cycle, busy stays low. A beat with last_item starts the sort.
//  Sort: one shared key comparator over one RAM read port; each sift level steps through
//  ST_SIFT_L, ST_SIFT_R, ST_SIFT_C (right child only) and ST_SIFT_D, or stops at a leaf.
//  Output: n beats back to back; out_valid is registered along with the RAM read data.
//  Reset (rst_n low) empties the load and clears sort_descending.
//  The receiver cannot stall; busy holds off new records until output is issued.
`timescale 1ns / 1ps
`default_nettype none

module heap_sort_by_key_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hsk_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [hsk_pkg::PDATA_W-1:0]   pwdata,
    output logic      [hsk_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [hsk_pkg::KEY_W-1:0]     sort_key,
    input  wire logic [hsk_pkg::ID_W-1:0]      item_id,
    input  wire logic [hsk_pkg::PLD_W-1:0]     payload,
    input  wire logic                          last_item,
    output logic                               out_valid,
    output logic      [hsk_pkg::KEY_W-1:0]     out_key,
    output logic      [hsk_pkg::ID_W-1:0]      out_id,
    output logic      [hsk_pkg::PLD_W-1:0]     out_payload,
    output logic                               out_last,
    output logic                               out_dropped
);
    import hsk_pkg::*;

    logic             desc_reg, desc_next;
    logic             reg_hit;
    rec_t             in_rec;
    ram_wr_t          ram_wr;
    logic [IDX_W-1:0] ram_raddr;
    rec_t             ram_rdata;
    logic [KEY_W-1:0] cmp_b_key;
    logic             cmp_above;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_SORT_DESC);

    always_comb
    begin
        desc_next = desc_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            desc_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = {{(PDATA_W-1){1'b0}}, desc_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
        end
        else
        begin
            desc_reg <= desc_next;
        end
    end

    assign in_rec.key     = sort_key;
    assign in_rec.id      = item_id;
    assign in_rec.payload = payload;

    hsk_ram u_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hsk_cmp u_cmp (
        .a_key (ram_rdata.key),
        .b_key (cmp_b_key),
        .desc  (desc_reg),
        .above (cmp_above)
    );

    hsk_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .in_rec       (in_rec),
        .last_item    (last_item),
        .busy         (busy),
        .ram_wr       (ram_wr),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .cmp_b_key    (cmp_b_key),
        .cmp_above    (cmp_above),
        .emit_valid   (out_valid),
        .emit_last    (out_last),
        .emit_dropped (out_dropped)
    );

    assign out_key     = ram_rdata.key;
    assign out_id      = ram_rdata.id;
    assign out_payload = ram_rdata.payload;

endmodule

`default_nettype wire

// ===== rtl/hsk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsk_ram (
    input  wire logic                   clk,
    input  wire hsk_pkg::ram_wr_t       wr,
    input  wire logic [hsk_pkg::IDX_W-1:0] raddr,
    output hsk_pkg::rec_t               rdata
);
    import hsk_pkg::*;

    rec_t mem [MAX_ITEMS];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/hsk_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// a ranks above b: larger key for max-heap, smaller key for min-heap
module hsk_cmp (
    input  wire logic [hsk_pkg::KEY_W-1:0] a_key,
    input  wire logic [hsk_pkg::KEY_W-1:0] b_key,
    input  wire logic                      desc,
    output logic                           above
);
    import hsk_pkg::*;

    always_comb
    begin
        if (desc)
        begin
            above = (a_key < b_key);
        end
        else
        begin
            above = (a_key > b_key);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hsk_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsk_seq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire hsk_pkg::rec_t             in_rec,
    input  wire logic                      last_item,
    output logic                           busy,
    output hsk_pkg::ram_wr_t               ram_wr,
    output logic [hsk_pkg::IDX_W-1:0]      ram_raddr,
    input  wire hsk_pkg::rec_t             ram_rdata,
    output logic [hsk_pkg::KEY_W-1:0]      cmp_b_key,
    input  wire logic                      cmp_above,
    output logic                           emit_valid,
    output logic                           emit_last,
    output logic                           emit_dropped
);
    import hsk_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  hs_reg, hs_next;
    logic [CNT_W-1:0]  bidx_reg, bidx_next;
    logic [IDX_W-1:0]  node_reg, node_next;
    logic              mode_reg, mode_next;
    rec_t              sift_reg, sift_next;
    rec_t              best_reg, best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              child_reg, child_next;
    logic              emit_reg, emit_next;
    logic              last_reg, last_next;
    logic              drop_reg, drop_next;

    logic [CNT_W-1:0]  l_idx;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  bidx_dec;
    logic [CNT_W-1:0]  bidx_inc;

    assign l_idx    = {node_reg, 1'b1};
    assign r_idx    = l_idx + CNT_W'(1);
    assign bidx_dec = bidx_reg - CNT_W'(1);
    assign bidx_inc = bidx_reg + CNT_W'(1);

    assign busy         = (state_reg != ST_IDLE);
    assign emit_valid   = emit_reg;
    assign emit_last    = last_reg;
    assign emit_dropped = drop_reg;
    assign cmp_b_key    = (state_reg == ST_SIFT_R) ? sift_reg.key : best_reg.key;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && last_item)
                begin
                    state_next = ST_BLD;
                end
            end
            ST_BLD:
            begin
                state_next = (bidx_reg != '0) ? ST_BLD_LD : ST_SRT;
            end
            ST_BLD_LD:
            begin
                state_next = ST_SIFT_L;
            end
            ST_SIFT_L:
            begin
                if (l_idx < hs_reg)
                begin
                    state_next = ST_SIFT_R;
                end
                else
                begin
                    state_next = mode_reg ? ST_SRT : ST_BLD;
                end
            end
            ST_SIFT_R:
            begin
                state_next = (r_idx < hs_reg) ? ST_SIFT_C : ST_SIFT_D;
            end
            ST_SIFT_C:
            begin
                state_next = ST_SIFT_D;
            end
            ST_SIFT_D:
            begin
                if (child_reg)
                begin
                    state_next = ST_SIFT_L;
                end
                else
                begin
                    state_next = mode_reg ? ST_SRT : ST_BLD;
                end
            end
            ST_SRT:
            begin
                state_next = (bidx_reg > CNT_W'(1)) ? ST_SRT_R0 : ST_EMIT;
            end
            ST_SRT_R0:
            begin
                state_next = ST_SRT_WE;
            end
            ST_SRT_WE:
            begin
                state_next = ST_SIFT_L;
            end
            ST_EMIT:
            begin
                if (bidx_inc == cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        hs_next       = hs_reg;
        bidx_next     = bidx_reg;
        node_next     = node_reg;
        mode_next     = mode_reg;
        sift_next     = sift_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        child_next    = child_reg;
        emit_next     = 1'b0;
        last_next     = 1'b0;
        drop_next     = ovf_reg;
        ram_wr        = '0;
        ram_raddr     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cnt_reg < MAX_CNT)
                    begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = cnt_reg[IDX_W-1:0];
                        ram_wr.data = in_rec;
                        cnt_next    = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        hs_next   = cnt_next;
                        bidx_next = cnt_next >> 1;
                        mode_next = 1'b0;
                    end
                end
            end
            ST_BLD:
            begin
                if (bidx_reg != '0)
                begin
                    ram_raddr = bidx_dec[IDX_W-1:0];
                    node_next = bidx_dec[IDX_W-1:0];
                    bidx_next = bidx_dec;
                end
                else
                begin
                    bidx_next = cnt_reg;
                    mode_next = 1'b1;
                end
            end
            ST_BLD_LD:
            begin
                sift_next = ram_rdata;
            end
            ST_SIFT_L:
            begin
                if (l_idx < hs_reg)
                begin
                    ram_raddr = l_idx[IDX_W-1:0];
                end
                else
                begin
                    ram_wr.en   = 1'b1;
                    ram_wr.addr = node_reg;
                    ram_wr.data = sift_reg;
                end
            end
            ST_SIFT_R:
            begin
                if (cmp_above)
                begin
                    best_next     = ram_rdata;
                    best_idx_next = l_idx[IDX_W-1:0];
                    child_next    = 1'b1;
                end
                else
                begin
                    best_next  = sift_reg;
                    child_next = 1'b0;
                end
                if (r_idx < hs_reg)
                begin
                    ram_raddr = r_idx[IDX_W-1:0];
                end
            end
            ST_SIFT_C:
            begin
                if (cmp_above)
                begin
                    best_next     = ram_rdata;
                    best_idx_next = r_idx[IDX_W-1:0];
                    child_next    = 1'b1;
                end
            end
            ST_SIFT_D:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = node_reg;
                ram_wr.data = child_reg ? best_reg : sift_reg;
                if (child_reg)
                begin
                    node_next = best_idx_reg;
                end
            end
            ST_SRT:
            begin
                if (bidx_reg > CNT_W'(1))
                begin
                    ram_raddr = bidx_dec[IDX_W-1:0];
                end
                else
                begin
                    bidx_next = '0;
                end
            end
            ST_SRT_R0:
            begin
                // tail entry becomes the value sifted from the root
                sift_next = ram_rdata;
                ram_raddr = '0;
            end
            ST_SRT_WE:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = bidx_dec[IDX_W-1:0];
                ram_wr.data = ram_rdata;
                hs_next     = bidx_dec;
                node_next   = '0;
                bidx_next   = bidx_dec;
            end
            ST_EMIT:
            begin
                ram_raddr = bidx_reg[IDX_W-1:0];
                emit_next = 1'b1;
                last_next = (bidx_inc == cnt_reg);
                bidx_next = bidx_inc;
                if (bidx_inc == cnt_reg)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default:
            begin
                emit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            hs_reg    <= '0;
            bidx_reg  <= '0;
            node_reg  <= '0;
            mode_reg  <= 1'b0;
            child_reg <= 1'b0;
            emit_reg  <= 1'b0;
            last_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            hs_reg    <= hs_next;
            bidx_reg  <= bidx_next;
            node_reg  <= node_next;
            mode_reg  <= mode_next;
            child_reg <= child_next;
            emit_reg  <= emit_next;
            last_reg  <= last_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sift_reg     <= sift_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
    end

endmodule

`default_nettype wire

// ===== rtl/hsk_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsk_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic last_item,
    input wire logic out_valid,
    input wire logic out_last,
    input wire logic out_dropped
);
    import hsk_pkg::*;

    // a last beat always starts a sort
    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_item |=> busy)
        else $error("last beat did not start a sort");

    // results of a run come back to back
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |=> out_valid)
        else $error("gap inside a result run");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |=> !out_valid)
        else $error("result after the last beat of a run");

    a_drop_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |=> $stable(out_dropped))
        else $error("drop flag changed within a run");

endmodule

bind heap_sort_by_key_top hsk_chk u_hsk_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_last    (out_last),
    .out_dropped (out_dropped)
);

`default_nettype wire
